/* sv/pmg_pkg.sv */
// Shared types, constants and helpers for the phase misfit gradient block.
// Used by every module of the block; depends on nothing else.
package pmg_pkg;

    localparam int CORDIC_STEPS = 24;
    localparam int DIV_STEPS    = 49;
    localparam int CELLS        = DIV_STEPS;
    localparam int STEP_W       = $clog2(CELLS);
    localparam int XW           = 36;
    localparam int ZW           = 32;
    localparam int RW           = 64;
    localparam int QW           = 49;
    localparam int MW           = 34;
    localparam int DW           = QW + 2;

    localparam logic [1:0] CFG_USE_REAL = 2'd0;
    localparam logic [1:0] CFG_OFF_EN   = 2'd1;
    localparam logic [1:0] CFG_OFF_RE   = 2'd2;
    localparam logic [1:0] CFG_OFF_IM   = 2'd3;

    typedef logic [STEP_W-1:0] t_step;

    localparam logic signed [ZW-1:0] ATAN_TAB [32] = '{
        32'sd210828714, 32'sd124459457, 32'sd65760959, 32'sd33381290,
        32'sd16755422, 32'sd8385879, 32'sd4193963, 32'sd2097109,
        32'sd1048571, 32'sd524287, 32'sd262144, 32'sd131072,
        32'sd65536, 32'sd32768, 32'sd16384, 32'sd8192,
        32'sd4096, 32'sd2048, 32'sd1024, 32'sd512,
        32'sd256, 32'sd128, 32'sd64, 32'sd32,
        32'sd16, 32'sd8, 32'sd4, 32'sd2,
        32'sd1, 32'sd0, 32'sd0, 32'sd0
    };

    typedef struct packed {
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
        logic [RW-1:0]        rem;
        logic [RW-1:0]        den;
        logic [QW-1:0]        q;
        logic                 nbit;
        logic                 neg;
    } t_lane;

    typedef struct packed {
        logic valid;
        logic zero;
    } t_flags;

    function automatic logic [31:0] abs32(input logic signed [31:0] v);
        logic signed [31:0] n;
        n = -v;
        return v[31] ? 32'(n) : 32'(v);
    endfunction

endpackage

/* sv/pmg_cell.sv */
// One cell of the chain: a restoring divide step and, while i_step is below CORDIC_STEPS, a CORDIC vectoring step.
// Depends on pmg_pkg.
module pmg_cell (
    input  logic           i_clk,
    input  logic           i_en,
    input  pmg_pkg::t_step i_step,
    input  pmg_pkg::t_lane i_lane,
    output pmg_pkg::t_lane o_lane
);
    import pmg_pkg::*;

    t_lane                r_lane;
    t_lane                n_lane;
    logic [4:0]           k;
    logic                 cordic_on;
    logic signed [XW-1:0] dx;
    logic signed [XW-1:0] dy;
    logic [RW:0]          shifted;
    logic [RW:0]          diff;
    logic                 ge;

    always_comb begin
        k         = i_step[4:0];
        cordic_on = i_step < t_step'(CORDIC_STEPS);
        dx        = i_lane.y >>> k;
        dy        = i_lane.x >>> k;
        shifted   = {i_lane.rem, i_lane.nbit};
        diff      = shifted - {1'b0, i_lane.den};
        ge        = shifted >= {1'b0, i_lane.den};
        n_lane    = i_lane;
        if (cordic_on) begin
            if (!i_lane.y[XW-1]) begin
                n_lane.x = i_lane.x + dx;
                n_lane.y = i_lane.y - dy;
                n_lane.z = i_lane.z + ATAN_TAB[k];
            end else begin
                n_lane.x = i_lane.x - dx;
                n_lane.y = i_lane.y + dy;
                n_lane.z = i_lane.z - ATAN_TAB[k];
            end
        end
        n_lane.rem  = ge ? diff[RW-1:0] : shifted[RW-1:0];
        n_lane.q    = {i_lane.q[QW-2:0], ge};
        n_lane.nbit = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lane <= n_lane;
        end
    end

    assign o_lane = r_lane;

endmodule

/* sv/pmg_mult.sv */
// Product stages: |misfit| * |derivative| * |weight| with scaling, sign and saturation.
// Depends on pmg_pkg.
module pmg_mult (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  pmg_pkg::t_flags          i_flags,
    input  logic signed [pmg_pkg::MW-1:0] i_misfit,
    input  logic signed [pmg_pkg::DW-1:0] i_deriv,
    input  logic signed [31:0]       i_weight,
    output pmg_pkg::t_flags          o_flags,
    output logic [31:0]              o_residual
);
    import pmg_pkg::*;

    t_flags        r0_f, r1_f, r2_f, r3_f;
    logic          r0_neg, r1_neg, r2_neg, r3_neg;
    logic [MW-1:0] r0_m;
    logic [DW-1:0] r0_d;
    logic [31:0]   r0_w, r1_w, r2_w;
    logic [59:0]   r1_pl;
    logic [58:0]   r1_ph;
    logic [52:0]   r2_p1;
    logic [58:0]   r3_a;
    logic [57:0]   r3_b;
    logic signed [MW-1:0] neg_m;
    logic signed [DW-1:0] neg_d;
    logic [84:0]   sum1;
    logic [84:0]   prod;
    logic [56:0]   r;

    always_comb begin
        neg_m = -i_misfit;
        neg_d = -i_deriv;
        sum1  = {25'd0, r1_pl} + {r1_ph, 26'd0};
        prod  = {26'd0, r3_a} + {r3_b, 27'd0};
        r     = prod[84:28];
        if (r3_f.zero) begin
            o_residual = 32'd0;
        end else if (r3_neg) begin
            o_residual = (r > 57'h80000000) ? 32'h80000000 : 32'(57'd0 - r);
        end else begin
            o_residual = (r > 57'h7FFFFFFF) ? 32'h7FFFFFFF : r[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_f.valid <= 1'b0;
            r1_f.valid <= 1'b0;
            r2_f.valid <= 1'b0;
            r3_f.valid <= 1'b0;
        end else if (i_en) begin
            r0_f <= i_flags;
            r1_f <= r0_f;
            r2_f <= r1_f;
            r3_f <= r2_f;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r0_neg    <= !(i_weight[31] ^ i_misfit[MW-1] ^ i_deriv[DW-1]);
            r0_m      <= i_misfit[MW-1] ? MW'(neg_m) : MW'(i_misfit);
            r0_d      <= i_deriv[DW-1] ? DW'(neg_d) : DW'(i_deriv);
            r0_w      <= abs32(i_weight);
            r1_neg    <= r0_neg;
            r1_w      <= r0_w;
            r1_pl     <= r0_m * r0_d[25:0];
            r1_ph     <= r0_m * r0_d[DW-1:26];
            r2_neg    <= r1_neg;
            r2_w      <= r1_w;
            r2_p1     <= sum1[84:32];
            r3_neg    <= r2_neg;
            r3_a      <= r2_p1[26:0] * r2_w;
            r3_b      <= r2_p1[52:27] * r2_w;
        end
    end

    assign o_flags = r3_f;

endmodule

/* sv/phase_misfit_gradient.sv */
// Phase misfit gradient: per-sample residual -w * (arg(z) - phi) * d(arg z) in Q16.16.
// Top level; depends on pmg_pkg, pmg_cell and pmg_mult.
//
// Usage: each input item on the s_axis channel carries one complex sample, the
// measured phase and a test weight; each yields exactly one item on m_axis
// with the saturated residual in tdata and the zero magnitude flag in tuser.
// Configuration is written through i_cfg_we, i_cfg_idx and i_cfg_data while
// no items are in flight.
// An item passes 57 registers, the first loaded at the edge that accepts it:
// one input stage, one squaring stage, one setup stage, 49 cells of the chain
// (one divide step each, the first 24 also one CORDIC step), four product
// stages and the output register. Throughput is one item per cycle while the
// skid register is empty, set by the chain of cells.
// When the receiver stalls, the output register holds and a skid register
// takes one more item; the pipeline then freezes and s_axis_tready drops
// until the skid register drains. Reset clears all valid flags and loads the
// configuration defaults.
module phase_misfit_gradient (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,  // real_part, imag_part, measured_phase, test_weight
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [31:0]  m_axis_tdata,  // residual
    output logic         m_axis_tuser,  // zero_magnitude
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_idx,
    input  logic [31:0]  i_cfg_data
);
    import pmg_pkg::*;

    logic               r_use_real, r_off_en;
    logic signed [31:0] r_off_re, r_off_im;

    logic               w_en;
    logic               r0_v;
    logic signed [31:0] r0_re, r0_im, r0_meas, r0_w;
    logic               r1_v;
    logic signed [31:0] r1_re, r1_im, r1_ore, r1_oim, r1_meas, r1_w;
    logic [63:0]        r1_sq [4];
    logic               r1_zs, r1_zr;

    t_lane              n_init [2];
    t_lane              w_lane [CELLS+1][2];
    logic               r_cv [CELLS+1];
    logic               r_cz [CELLS+1];
    logic signed [31:0] r_cmeas [CELLS+1];
    logic signed [31:0] r_cw [CELLS+1];

    logic signed [DW-2:0] d_s, d_r;
    logic signed [DW-1:0] d_tot;
    logic signed [MW-1:0] misfit;
    t_flags             w_fin;
    t_flags             w_pf;
    logic [31:0]        w_pres;

    logic               r_out_v, r_out_z, r_skid_v, r_skid_z;
    logic [31:0]        r_out_res, r_skid_res;

    assign w_en          = !r_skid_v;
    assign s_axis_tready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_use_real <= 1'b1;
            r_off_en   <= 1'b0;
            r_off_re   <= 32'sd65536;
            r_off_im   <= 32'sd0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_USE_REAL: r_use_real <= i_cfg_data[0];
                CFG_OFF_EN:   r_off_en   <= i_cfg_data[0];
                CFG_OFF_RE:   r_off_re   <= i_cfg_data;
                CFG_OFF_IM:   r_off_im   <= i_cfg_data;
                default:      r_off_im   <= r_off_im;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_v <= 1'b0;
            r1_v <= 1'b0;
        end else if (w_en) begin
            r0_v <= s_axis_tvalid;
            r1_v <= r0_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r0_re    <= s_axis_tdata[31:0];
            r0_im    <= s_axis_tdata[63:32];
            r0_meas  <= s_axis_tdata[95:64];
            r0_w     <= s_axis_tdata[127:96];
            r1_re    <= r0_re;
            r1_im    <= r0_im;
            r1_ore   <= r_off_re;
            r1_oim   <= r_off_im;
            r1_meas  <= r0_meas;
            r1_w     <= r0_w;
            r1_sq[0] <= abs32(r0_re) * abs32(r0_re);
            r1_sq[1] <= abs32(r0_im) * abs32(r0_im);
            r1_sq[2] <= abs32(r_off_re) * abs32(r_off_re);
            r1_sq[3] <= abs32(r_off_im) * abs32(r_off_im);
            r1_zs    <= (r0_re == 32'sd0) && (r0_im == 32'sd0);
            r1_zr    <= (r_off_re == 32'sd0) && (r_off_im == 32'sd0);
        end
    end

    // Lane 0 is the sample, lane 1 the reference.
    always_comb begin
        for (int l = 0; l < 2; l++) begin
            logic signed [31:0] re;
            logic signed [31:0] im;
            logic signed [XW-1:0] xe;
            logic signed [XW-1:0] ye;
            logic [31:0] n;
            re = (l == 0) ? r1_re : r1_ore;
            im = (l == 0) ? r1_im : r1_oim;
            xe = XW'(re);
            ye = XW'(im);
            n  = r_use_real ? abs32(im) : abs32(re);
            n_init[l].den  = r1_sq[2*l] + r1_sq[2*l+1];
            n_init[l].rem  = RW'(n[31:1]);
            n_init[l].nbit = n[0];
            n_init[l].q    = '0;
            n_init[l].neg  = r_use_real ? (!im[31] && (im != 32'sd0)) : re[31];
            if (re[31] && !im[31]) begin
                n_init[l].x = ye;
                n_init[l].y = -xe;
                n_init[l].z = ATAN_TAB[0] <<< 1;
            end else if (re[31]) begin
                n_init[l].x = -ye;
                n_init[l].y = xe;
                n_init[l].z = -(ATAN_TAB[0] <<< 1);
            end else begin
                n_init[l].x = xe;
                n_init[l].y = ye;
                n_init[l].z = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cv[0] <= 1'b0;
        end else if (w_en) begin
            r_cv[0] <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_cz[0]    <= r1_zs || (r_off_en && r1_zr);
            r_cmeas[0] <= r1_meas;
            r_cw[0]    <= r1_w;
        end
    end

    for (genvar l = 0; l < 2; l++) begin : g_init
        t_lane r_init;
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_init <= n_init[l];
            end
        end
        assign w_lane[0][l] = r_init;
    end

    for (genvar g = 0; g < CELLS; g++) begin : g_cell
        for (genvar l = 0; l < 2; l++) begin : g_lane
            pmg_cell u_cell (
                .i_clk  (i_clk),
                .i_en   (w_en),
                .i_step (t_step'(g)),
                .i_lane (w_lane[g][l]),
                .o_lane (w_lane[g+1][l])
            );
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_cv[g+1] <= 1'b0;
            end else if (w_en) begin
                r_cv[g+1] <= r_cv[g];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_cz[g+1]    <= r_cz[g];
                r_cmeas[g+1] <= r_cmeas[g];
                r_cw[g+1]    <= r_cw[g];
            end
        end
    end

    always_comb begin
        d_s = w_lane[CELLS][0].neg ? -(DW-1)'({1'b0, w_lane[CELLS][0].q})
                                   :  (DW-1)'({1'b0, w_lane[CELLS][0].q});
        d_r = w_lane[CELLS][1].neg ? -(DW-1)'({1'b0, w_lane[CELLS][1].q})
                                   :  (DW-1)'({1'b0, w_lane[CELLS][1].q});
        d_tot  = r_off_en ? (DW'(d_s) - DW'(d_r)) : DW'(d_s);
        misfit = MW'(w_lane[CELLS][0].z) - MW'(r_cmeas[CELLS])
               - (r_off_en ? MW'(w_lane[CELLS][1].z) : MW'(0));
        w_fin.valid = r_cv[CELLS];
        w_fin.zero  = r_cz[CELLS];
    end

    pmg_mult u_mult (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_en),
        .i_flags    (w_fin),
        .i_misfit   (misfit),
        .i_deriv    (d_tot),
        .i_weight   (r_cw[CELLS]),
        .o_flags    (w_pf),
        .o_residual (w_pres)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (w_en) begin
            if (w_pf.valid) begin
                if (r_out_v && !m_axis_tready) begin
                    r_skid_v <= 1'b1;
                end else begin
                    r_out_v <= 1'b1;
                end
            end else if (m_axis_tready) begin
                r_out_v <= 1'b0;
            end
        end else if (m_axis_tready) begin
            r_skid_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (w_pf.valid) begin
                if (r_out_v && !m_axis_tready) begin
                    r_skid_res <= w_pres;
                    r_skid_z   <= w_pf.zero;
                end else begin
                    r_out_res <= w_pres;
                    r_out_z   <= w_pf.zero;
                end
            end
        end else if (m_axis_tready) begin
            r_out_res <= r_skid_res;
            r_out_z   <= r_skid_z;
        end
    end

    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = r_out_res;
    assign m_axis_tuser  = r_out_z;

endmodule
